// ----- sv/tccw_pkg.sv -----
`default_nettype none

package tccw_pkg;

  // Field widths of the item payloads
  localparam int OpW       = 2;
  localparam int CharW     = 8;
  localparam int AttrW     = 8;
  localparam int CellW     = 16;
  localparam int RowFieldW = 5;
  localparam int ColFieldW = 7;

  // Operation codes
  localparam logic [OpW-1:0] OpPut   = 2'd0;
  localparam logic [OpW-1:0] OpRead  = 2'd1;
  localparam logic [OpW-1:0] OpClear = 2'd2;

  // Control bytes and blanking
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChLf    = 8'h0a;
  localparam logic [CharW-1:0] ChCr    = 8'h0d;
  localparam logic [CharW-1:0] ChBlank = 8'h20;

  localparam logic [AttrW-1:0] ResetAttr = 8'd15;
  localparam int TabStop    = 4;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [OpW-1:0]       op;
    logic [CharW-1:0]     char_code;
    logic [RowFieldW-1:0] read_row;
    logic [ColFieldW-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [CellW-1:0]     cell_word;
    logic [RowFieldW-1:0] cursor_row;
    logic [ColFieldW-1:0] cursor_col;
  } out_item_t;

  // Command classes decided by the front end
  typedef enum logic [2:0] {
    CmdIgnore,
    CmdNewline,
    CmdReturn,
    CmdTab,
    CmdPrint,
    CmdRead,
    CmdClear
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [CharW-1:0]     char_code;
    logic [RowFieldW-1:0] read_row;
    logic [ColFieldW-1:0] read_col;
    logic                 read_ok;
  } cmd_t;

  typedef enum logic [3:0] {
    StInit,
    StIdle,
    StDispatch,
    StReadWait,
    StScrollCopy,
    StScrollBlank,
    StFill,
    StResult
  } back_state_e;

endpackage

`default_nettype wire

// ----- sv/tccw_front.sv -----
`default_nettype none

module tccw_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire tccw_pkg::in_item_t in_item_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output tccw_pkg::cmd_t         q_cmd_o
);
  import tccw_pkg::*;

  // Take an item whenever the queue has room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the item into a command for the back end
  always_comb begin
    q_cmd_o.char_code = in_item_i.char_code;
    q_cmd_o.read_row  = in_item_i.read_row;
    q_cmd_o.read_col  = in_item_i.read_col;
    q_cmd_o.read_ok   = (in_item_i.read_row < ROWS) && (in_item_i.read_col < COLS);
    case (in_item_i.op)
      OpPut: begin
        case (in_item_i.char_code)
          ChNul:   q_cmd_o.kind = CmdIgnore;
          ChLf:    q_cmd_o.kind = CmdNewline;
          ChCr:    q_cmd_o.kind = CmdReturn;
          ChTab:   q_cmd_o.kind = CmdTab;
          default: q_cmd_o.kind = CmdPrint;
        endcase
      end
      OpRead:  q_cmd_o.kind = CmdRead;
      OpClear: q_cmd_o.kind = CmdClear;
      default: q_cmd_o.kind = CmdIgnore;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/tccw_fifo.sv -----
`default_nettype none

module tccw_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tccw_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output tccw_pkg::cmd_t      cmd_o
);
  import tccw_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/tccw_back.sv -----
`default_nettype none

module tccw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [tccw_pkg::AttrW-1:0] cfg_wdata_i,
  input  wire logic                     q_valid_i,
  input  wire tccw_pkg::cmd_t           q_cmd_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output tccw_pkg::out_item_t           out_item_o
);
  import tccw_pkg::*;

  localparam int Cells   = ROWS * COLS;
  localparam int CopyLen = (ROWS - 1) * COLS;
  localparam int AddrW   = $clog2(Cells);
  localparam int CntW    = $clog2(Cells + 1);
  localparam int RowW    = $clog2(ROWS);
  localparam int ColW    = $clog2(COLS + 1);

  back_state_e      state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CellW-1:0] word_q, word_d;
  logic [AttrW-1:0] attr_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic [CellW-1:0] mem_q [Cells];
  logic [CellW-1:0] rdata_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [CellW-1:0] mem_wdata;

  logic [AddrW-1:0] cur_addr, rd_addr;
  logic [ColW-1:0]  col_nx;
  logic             at_wrap, last_row, tab_done, copy_end, fill_end, out_free;

  // Shared conditions
  assign cur_addr = AddrW'(AddrW'(row_q) * AddrW'(COLS) + AddrW'(col_q));
  assign rd_addr  = AddrW'(AddrW'(cmd_q.read_row) * AddrW'(COLS) + AddrW'(cmd_q.read_col));
  assign col_nx   = col_q + 1'b1;
  assign at_wrap  = (col_q == ColW'(COLS));
  assign last_row = (row_q == RowW'(ROWS - 1));
  assign tab_done = ((col_nx % TabStop) == '0) || (col_nx == ColW'(COLS));
  assign copy_end = (cnt_q == CntW'(CopyLen));
  assign fill_end = (cnt_q == CntW'(Cells - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StInit:   if (fill_end) state_d = StIdle;
      StIdle:   if (q_valid_i) state_d = StDispatch;
      StDispatch: begin
        case (cmd_q.kind)
          CmdNewline: state_d = last_row ? StScrollCopy : StResult;
          CmdPrint: begin
            if (at_wrap) state_d = last_row ? StScrollCopy : StDispatch;
            else         state_d = StResult;
          end
          CmdTab: begin
            if (at_wrap)       state_d = last_row ? StScrollCopy : StDispatch;
            else if (tab_done) state_d = StResult;
            else               state_d = StDispatch;
          end
          CmdRead:  state_d = cmd_q.read_ok ? StReadWait : StResult;
          CmdClear: state_d = StFill;
          default:  state_d = StResult;
        endcase
      end
      StReadWait:   state_d = StResult;
      StScrollCopy: if (copy_end) state_d = StScrollBlank;
      StScrollBlank: begin
        if (fill_end) state_d = (cmd_q.kind == CmdNewline) ? StResult : StDispatch;
      end
      StFill:   if (fill_end) state_d = StResult;
      StResult: if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Datapath and memory control per state
  always_comb begin
    cmd_d       = cmd_q;
    row_d       = row_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    word_d      = word_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cur_addr;
    mem_wdata   = {attr_q, ChBlank};
    mem_re      = 1'b0;
    mem_raddr   = rd_addr;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      StInit: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(cnt_q);
        mem_wdata = {ResetAttr, ChBlank};
        if (!fill_end) cnt_d = cnt_q + 1'b1;
      end
      StIdle: begin
        q_pop_o = q_valid_i;
        cmd_d   = q_cmd_i;
      end
      StDispatch: begin
        word_d = '0;
        case (cmd_q.kind)
          CmdNewline: begin
            col_d = '0;
            if (last_row) cnt_d = '0;
            else          row_d = row_q + 1'b1;
          end
          CmdReturn: col_d = '0;
          CmdPrint, CmdTab: begin
            if (at_wrap) begin
              // pending wrap: newline before the cell goes down
              col_d = '0;
              if (last_row) cnt_d = '0;
              else          row_d = row_q + 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {attr_q, (cmd_q.kind == CmdPrint) ? cmd_q.char_code : ChBlank};
              col_d     = col_nx;
            end
          end
          CmdRead: mem_re = cmd_q.read_ok;
          CmdClear: begin
            row_d = '0;
            col_d = '0;
            cnt_d = '0;
          end
          default: ;
        endcase
      end
      StReadWait: word_d = rdata_q;
      StScrollCopy: begin
        // read one row ahead, write the cell fetched last cycle
        mem_re    = !copy_end;
        mem_raddr = AddrW'(cnt_q + CntW'(COLS));
        mem_we    = (cnt_q != '0);
        mem_waddr = AddrW'(cnt_q - 1'b1);
        mem_wdata = rdata_q;
        if (!copy_end) cnt_d = cnt_q + 1'b1;
      end
      StScrollBlank, StFill: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(cnt_q);
        if (!fill_end) cnt_d = cnt_q + 1'b1;
      end
      StResult: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.cell_word  = word_q;
          out_d.cursor_row = RowFieldW'(row_q);
          out_d.cursor_col = ColFieldW'(col_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      attr_q      <= ResetAttr;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) attr_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    word_q <= word_d;
    out_q  <= out_d;
  end

  // Screen store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_result_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StResult && out_free) |=> out_valid_q)
    else $error("result not presented");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (col_q <= ColW'(COLS)) && (row_q <= RowW'(ROWS - 1)))
    else $error("cursor out of range");

  a_blank_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScrollBlank) |-> last_row && (col_q == '0))
    else $error("scroll without cursor on last row");

  a_pop_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == StDispatch))
    else $error("popped command not dispatched");

  a_write_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr <= AddrW'(Cells - 1)))
    else $error("screen write out of range");

endmodule

`default_nettype wire

// ----- sv/text_console_char_writer.sv -----
`default_nettype none

// Text console engine: a ROWS x COLS screen of 16-bit cells (attribute high byte,
// character low byte) with a cursor. After reset the screen store is swept to blanks
// with attribute 15, one cell a cycle; the queue takes up to two items meanwhile, but
// none is carried out until the sweep is done, and attribute writes are accepted
// throughout. Items enter a two-entry queue, so the input keeps accepting while a
// result waits. Each item gives one result; a read out of range skips the store. A
// tab writes blank cells up to the next tab stop, one cell write per cycle through
// the single write port; a pending wrap first moves the cursor to the next line for
// a print or a tab, plus the scroll below when on the last row. A newline on the last
// row copies the rows up one and blanks the last row, and a clear sweeps the screen
// to blanks; the store's single read and write port makes both go one cell at a time.
module text_console_char_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [tccw_pkg::AttrW-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire tccw_pkg::in_item_t        in_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output tccw_pkg::out_item_t            out_item_o
);
  import tccw_pkg::*;

  cmd_t push_cmd, head_cmd;
  logic push, full, head_valid, pop;

  // Classify incoming items
  tccw_front #(.COLS(COLS), .ROWS(ROWS)) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_cmd_o    (push_cmd)
  );

  // Command queue between front and back
  tccw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  // Execute commands on the screen store
  tccw_back #(.COLS(COLS), .ROWS(ROWS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (head_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
